### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rs, ante, cons)
`define ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### hdl/cgl_pkg.sv
`default_nettype none
package cgl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // widest divider operand: p^2 + 2n^2 + pn + eps
  localparam int NUM_W = 66;
  localparam int ADDR_W = 3;

  localparam logic [1:0] SLOPE_MINMOD = 2'd0;
  localparam logic [1:0] SLOPE_VENKAT = 2'd1;
  localparam logic [1:0] SLOPE_CUBIC  = 2'd2;

  localparam logic REG_SLOPE_MODE  = 1'b0;
  localparam logic REG_SECOND_MODE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_LIM_ONE, S_MUL_PP, S_MUL_PN, S_MUL_NN, S_ACC_NN,
    S_DIV_VK, S_DIV_PN, S_WAIT_LIM, S_LIM_DIV, S_CUB_Y, S_CUB_D,
    S_CUB_T, S_CUB_LIM, S_FOLD, S_SEC_SS, S_SEC_CHK, S_SEC_ONE, S_SEC_PASS,
    S_SEC_DIV, S_WAIT_DY, S_SEC_YY, S_SEC_YT, S_SEC_W, S_SEC_WL, S_SEC_R,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_LIM_ONE, CMD_MUL_PP, CMD_MUL_PN, CMD_MUL_NN,
    CMD_ACC_NN, CMD_DIV_VK, CMD_DIV_PN, CMD_LIM_DIV, CMD_CUB_Y, CMD_CUB_D,
    CMD_CUB_T, CMD_CUB_LIM, CMD_FOLD, CMD_SEC_SS, CMD_SEC_DIV, CMD_SEC_YY,
    CMD_SEC_YT, CMD_SEC_W, CMD_SEC_WL, CMD_SEC_R, CMD_SEC_ONE, CMD_SEC_PASS,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic fzero;
    logic ge_mm;
    logic ge_cub;
    logic last;
    logic div_busy;
    logic s_le_eps;
    logic s_ge_2eps;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### hdl/cgl_face_if.sv
`default_nettype none
interface cgl_face_if;
  logic        valid;
  logic        ready;
  logic [31:0] delta_min;
  logic [30:0] delta_max;
  logic [31:0] face_delta;
  logic [62:0] eps_squared;
  logic        last_face;

  modport source (output valid, delta_min, delta_max, face_delta, eps_squared, last_face,
                  input ready);
  modport sink (input valid, delta_min, delta_max, face_delta, eps_squared, last_face,
                output ready);
endinterface
`default_nettype wire

### hdl/cgl_result_if.sv
`default_nettype none
interface cgl_result_if #(parameter int FRAC_BITS = cgl_pkg::FRAC_BITS_DEF);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] coefficient;

  modport source (output valid, coefficient, input ready);
  modport sink (input valid, coefficient, output ready);
endinterface
`default_nettype wire

### hdl/cgl_div.sv
`default_nettype none
`include "assert_macros.svh"
module cgl_div #(
  parameter int FRAC_BITS = cgl_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cgl_pkg::NUM_W-1:0]  num,
  input  logic [cgl_pkg::NUM_W-1:0]  den,
  output logic                       busy,
  output logic [FRAC_BITS:0]         q
);
  import cgl_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic [NUM_W:0]   r;
  logic [NUM_W-1:0] dn;
  logic [CNT_W-1:0] cnt;
  logic             ge;
  logic [NUM_W:0]   diff;
  logic             sat;

  // restoring division, one quotient bit a cycle, msb first
  always_comb begin
    ge   = r >= {1'b0, dn};
    diff = ge ? (r - {1'b0, dn}) : r;
    sat  = {1'b0, num} >= {den, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !sat;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= {1'b0, num};
      dn  <= den;
      cnt <= CNT_W'(FRAC_BITS + 1);
      q   <= sat ? '1 : '0;
    end else if (busy) begin
      r   <= {diff[NUM_W-1:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
      q   <= {q[CW-2:0], ge};
    end
  end

  `ASSERT_IMP(a_start_idle, clk, rst, start, !busy)

endmodule
`default_nettype wire

### hdl/cgl_dp.sv
`default_nettype none
`include "assert_macros.svh"
module cgl_dp #(
  parameter int FRAC_BITS = cgl_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cgl_pkg::cmd_t        cmd,
  output cgl_pkg::status_t     status,
  input  logic [31:0]          delta_min,
  input  logic [30:0]          delta_max,
  input  logic [31:0]          face_delta,
  input  logic [62:0]          eps_squared,
  input  logic                 last_face,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   coefficient
);
  import cgl_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0]    ONE = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]    COEF_MAX = '1;
  localparam logic [31:0]      ONE32 = 32'(1) << FRAC_BITS;
  // ceil(2^32 / 7): exact floor(x / 7) for x below 2^32 / 3
  localparam logic [31:0]      RECIP7 = 32'd613566757;

  logic [31:0]      p, n, span;
  logic [62:0]      eps;
  logic             last, fzero;
  logic [63:0]      prod;
  logic [NUM_W-1:0] acc_num, acc_den;
  logic [CW-1:0]    y, d, dy, w, lim, res, runmin;

  logic [31:0]      pneg, f_mag, p_in, span_in;
  logic [31:0]      mul_a, mul_b;
  logic             mul_en;
  logic             div_start, div_busy;
  logic [NUM_W-1:0] div_num, div_den;
  logic [CW-1:0]    q;
  logic [63:0]      t_cub, t_sec;
  logic [CW-1:0]    cub_diff, cub_lim, sec_w, sec_r;
  logic [CW:0]      sec_sum;
  logic [34:0]      p4, n7;

  // face decode: clamp delta_min and pick the side facing the delta
  always_comb begin
    pneg    = delta_min[31] ? (~delta_min + 32'd1) : '0;
    f_mag   = face_delta[31] ? (~face_delta + 32'd1) : face_delta;
    p_in    = face_delta[31] ? pneg : {1'b0, delta_max};
    span_in = pneg + {1'b0, delta_max};
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd)
      CMD_MUL_PP: begin mul_a = p; mul_b = p; end
      CMD_MUL_PN: begin mul_a = p; mul_b = n; end
      CMD_MUL_NN: begin mul_a = n; mul_b = n; end
      // 4y / 7 by reciprocal multiplication
      CMD_CUB_Y:  begin mul_a = 32'(q) << 2; mul_b = RECIP7; end
      CMD_CUB_D: begin
        mul_a = 32'(prod >> 32);
        mul_b = 32'(prod >> 32);
      end
      CMD_CUB_T: begin
        mul_a = 32'(prod >> FRAC_BITS);
        mul_b = (ONE32 << 1) + 32'(d);
      end
      CMD_SEC_SS: begin mul_a = span; mul_b = span; end
      CMD_SEC_YY: begin mul_a = 32'(q); mul_b = 32'(q); end
      CMD_SEC_YT: begin
        mul_a = 32'(prod >> FRAC_BITS);
        mul_b = (ONE32 << 1) + ONE32 - (32'(dy) << 1);
      end
      CMD_SEC_WL: begin mul_a = 32'(ONE - w); mul_b = 32'(runmin); end
      default:    mul_en = 1'b0;
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd)
      CMD_DIV_VK:  begin div_num = acc_num; div_den = acc_den; end
      CMD_DIV_PN:  begin div_num = NUM_W'(p); div_den = NUM_W'(n); end
      CMD_SEC_DIV: begin div_num = NUM_W'(prod - 64'(eps)); div_den = NUM_W'(eps); end
      default:     div_start = 1'b0;
    endcase
  end

  cgl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .q     (q)
  );

  // cubic tail and smooth-region blend
  always_comb begin
    t_cub    = prod >> (FRAC_BITS + 2);
    cub_diff = y - CW'(t_cub);
    if (t_cub >= 64'(y)) begin
      cub_lim = '0;
    end else begin
      cub_lim = (cub_diff > ONE) ? ONE : cub_diff;
    end
    t_sec   = prod >> FRAC_BITS;
    sec_w   = (t_sec >= 64'(ONE)) ? '0 : (ONE - CW'(t_sec));
    sec_sum = {1'b0, w} + (CW + 1)'(prod >> FRAC_BITS);
    sec_r   = (sec_sum > {1'b0, COEF_MAX}) ? COEF_MAX : sec_sum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        p     <= p_in;
        n     <= f_mag;
        eps   <= eps_squared;
        span  <= span_in;
        last  <= last_face;
        fzero <= face_delta == '0;
      end
      CMD_LIM_ONE: lim <= ONE;
      CMD_MUL_PN: begin
        acc_num <= NUM_W'(prod) + NUM_W'(eps);
        acc_den <= NUM_W'(prod) + NUM_W'(eps);
      end
      CMD_MUL_NN: begin
        acc_num <= acc_num + (NUM_W'(prod) << 1);
        acc_den <= acc_den + NUM_W'(prod);
      end
      CMD_ACC_NN:   acc_den <= acc_den + (NUM_W'(prod) << 1);
      CMD_LIM_DIV:  lim <= q;
      CMD_CUB_Y:    y <= q;
      CMD_CUB_D:    d <= CW'(prod >> 32);
      CMD_CUB_LIM:  lim <= cub_lim;
      CMD_SEC_YY:   dy <= q;
      CMD_SEC_W:    w <= sec_w;
      CMD_SEC_R:    res <= sec_r;
      CMD_SEC_ONE:  res <= ONE;
      CMD_SEC_PASS: res <= runmin;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runmin <= ONE;
    end else if (cmd == CMD_EMIT) begin
      runmin <= ONE;
    end else if (cmd == CMD_FOLD && lim < runmin) begin
      runmin <= lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      coefficient <= res;
    end
  end

  always_comb begin
    p4 = {1'b0, p, 2'b00};
    n7 = {n, 3'b000} - {3'b000, n};
    status.fzero     = fzero;
    status.ge_mm     = p >= n;
    status.ge_cub    = p4 >= n7;
    status.last      = last;
    status.div_busy  = div_busy;
    status.s_le_eps  = prod <= {1'b0, eps};
    status.s_ge_2eps = prod >= {eps, 1'b0};
    status.out_free  = !out_valid || out_ready;
  end

  `ASSERT_IMP(a_min_bounded, clk, rst, 1'b1, runmin <= ONE)
  `ASSERT_IMP(a_emit_free, clk, rst, cmd == CMD_EMIT, !out_valid || out_ready)

endmodule
`default_nettype wire

### hdl/cgl_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module cgl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_ready,
  input  logic [1:0]       slope_mode,
  input  logic             second_mode,
  input  cgl_pkg::status_t status,
  output cgl_pkg::cmd_t    cmd
);
  import cgl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (face_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (status.fzero) state_next = S_LIM_ONE;
        else if (slope_mode == SLOPE_MINMOD)
          state_next = status.ge_mm ? S_LIM_ONE : S_DIV_PN;
        else if (slope_mode == SLOPE_CUBIC)
          state_next = status.ge_cub ? S_LIM_ONE : S_DIV_PN;
        else state_next = S_MUL_PP;
      end
      S_MUL_PP:   state_next = S_MUL_PN;
      S_MUL_PN:   state_next = S_MUL_NN;
      S_MUL_NN:   state_next = S_ACC_NN;
      S_ACC_NN:   state_next = S_DIV_VK;
      S_DIV_VK:   state_next = S_WAIT_LIM;
      S_DIV_PN:   state_next = S_WAIT_LIM;
      S_WAIT_LIM: begin
        if (!status.div_busy) begin
          state_next = (slope_mode == SLOPE_CUBIC) ? S_CUB_Y : S_LIM_DIV;
        end
      end
      S_LIM_DIV:  state_next = S_FOLD;
      S_LIM_ONE:  state_next = S_FOLD;
      S_CUB_Y:    state_next = S_CUB_D;
      S_CUB_D:    state_next = S_CUB_T;
      S_CUB_T:    state_next = S_CUB_LIM;
      S_CUB_LIM:  state_next = S_FOLD;
      S_FOLD: begin
        priority if (!status.last) state_next = S_IDLE;
        else if (second_mode) state_next = S_SEC_SS;
        else state_next = S_SEC_PASS;
      end
      S_SEC_SS:   state_next = S_SEC_CHK;
      S_SEC_CHK: begin
        priority if (status.s_le_eps) state_next = S_SEC_ONE;
        else if (status.s_ge_2eps) state_next = S_SEC_PASS;
        else state_next = S_SEC_DIV;
      end
      S_SEC_ONE:  state_next = S_EMIT;
      S_SEC_PASS: state_next = S_EMIT;
      S_SEC_DIV:  state_next = S_WAIT_DY;
      S_WAIT_DY:  if (!status.div_busy) state_next = S_SEC_YY;
      S_SEC_YY:   state_next = S_SEC_YT;
      S_SEC_YT:   state_next = S_SEC_W;
      S_SEC_W:    state_next = S_SEC_WL;
      S_SEC_WL:   state_next = S_SEC_R;
      S_SEC_R:    state_next = S_EMIT;
      S_EMIT:     if (status.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    face_ready = state == S_IDLE;
    unique case (state)
      S_IDLE:     cmd = face_valid ? CMD_LOAD : CMD_NOP;
      S_LIM_ONE:  cmd = CMD_LIM_ONE;
      S_MUL_PP:   cmd = CMD_MUL_PP;
      S_MUL_PN:   cmd = CMD_MUL_PN;
      S_MUL_NN:   cmd = CMD_MUL_NN;
      S_ACC_NN:   cmd = CMD_ACC_NN;
      S_DIV_VK:   cmd = CMD_DIV_VK;
      S_DIV_PN:   cmd = CMD_DIV_PN;
      S_LIM_DIV:  cmd = CMD_LIM_DIV;
      S_CUB_Y:    cmd = CMD_CUB_Y;
      S_CUB_D:    cmd = CMD_CUB_D;
      S_CUB_T:    cmd = CMD_CUB_T;
      S_CUB_LIM:  cmd = CMD_CUB_LIM;
      S_FOLD:     cmd = CMD_FOLD;
      S_SEC_SS:   cmd = CMD_SEC_SS;
      S_SEC_ONE:  cmd = CMD_SEC_ONE;
      S_SEC_PASS: cmd = CMD_SEC_PASS;
      S_SEC_DIV:  cmd = CMD_SEC_DIV;
      S_SEC_YY:   cmd = CMD_SEC_YY;
      S_SEC_YT:   cmd = CMD_SEC_YT;
      S_SEC_W:    cmd = CMD_SEC_W;
      S_SEC_WL:   cmd = CMD_SEC_WL;
      S_SEC_R:    cmd = CMD_SEC_R;
      S_EMIT:     cmd = status.out_free ? CMD_EMIT : CMD_NOP;
      default:    cmd = CMD_NOP;
    endcase
  end

  `ASSERT_IMP(a_idle_div_quiet, clk, rst, state == S_IDLE, !status.div_busy)
  `ASSERT_NXT(a_load_decide, clk, rst, cmd == CMD_LOAD, state == S_DECIDE)

endmodule
`default_nettype wire

### hdl/cell_gradient_limiter_core.sv
// channel   role   handshake        payload
// face      sink   valid / ready    delta_min, delta_max, face_delta, eps_squared, last_face
// result    source valid / ready    coefficient (unsigned Q1.F)
// apb       slave  psel / penable   slope_mode at 0x0, second_mode at 0x4
//
// one face at a time; a face of zero delta or a clipped ratio goes through decide, limit-to-one and fold
// otherwise minmod divides p by n, venkatakrishnan first builds its ratio from three products, cubic
// divides p by n and then applies the cubic tail, all on the shared restoring divider
// a last face then runs the second limiter when second_mode is set, else passes the minimum, then emits
// synchronous active-high reset; running minimum returns to 1.0
// result sits in an output register, so a stalled sink only blocks the next emit
`default_nettype none
module cell_gradient_limiter_core #(
  parameter int FRAC_BITS = cgl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  cgl_face_if.sink                      face,
  cgl_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cgl_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cgl_pkg::*;

  logic [1:0] slope_mode;
  logic       second_mode;
  logic       cfg_write;
  cmd_t       cmd;
  status_t    status;

  // config registers, written in the access phase of an apb transaction
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_mode  <= SLOPE_VENKAT;
      second_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SLOPE_MODE:  slope_mode  <= pwdata[1:0];
        REG_SECOND_MODE: second_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // readback of the selected register
  always_comb begin
    unique case (paddr[2])
      REG_SLOPE_MODE:  prdata = {30'd0, slope_mode};
      REG_SECOND_MODE: prdata = {31'd0, second_mode};
      default:         prdata = '0;
    endcase
  end

  // sequencer: one command per cycle to the datapath
  cgl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .face_valid  (face.valid),
    .face_ready  (face.ready),
    .slope_mode  (slope_mode),
    .second_mode (second_mode),
    .status      (status),
    .cmd         (cmd)
  );

  // operand registers, shared multiplier, divider and running minimum
  cgl_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .delta_min   (face.delta_min),
    .delta_max   (face.delta_max),
    .face_delta  (face.face_delta),
    .eps_squared (face.eps_squared),
    .last_face   (face.last_face),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .coefficient (result.coefficient)
  );

endmodule
`default_nettype wire
